/* rtl/core/ttg_pkg.sv */
package ttg_pkg;

	// grid and glyph geometry
	localparam int TEXT_COLUMNS_DEF = 30;
	localparam int TEXT_ROWS_DEF    = 20;
	localparam int GLYPH_HEIGHT     = 16;
	localparam int ROW_W            = 4;
	localparam int CUR_W            = 5;
	localparam int FONT_AW          = 12;
	localparam int CODE_W           = 8;
	localparam int COLOR_W          = 16;
	localparam int PIX_PER_ROW      = 8;
	localparam int X_W              = 8;
	localparam int Y_W              = 9;

	// character codes
	localparam logic [CODE_W-1:0] CODE_HOME    = 8'h00;
	localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'h0d;

	// item mode and result kind codes
	localparam logic MODE_RENDER = 1'b0;
	localparam logic MODE_FONT   = 1'b1;
	localparam logic KIND_CLEAR  = 1'b0;
	localparam logic KIND_GLYPH  = 1'b1;

	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_HEIGHT - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_GLYPH
	} seq_state_t;

	typedef struct packed {
		logic                                   kind;
		logic [X_W-1:0]                         pixel_x;
		logic [Y_W-1:0]                         pixel_y;
		logic [PIX_PER_ROW-1:0][COLOR_W-1:0]    pix;
		logic                                   last;
	} result_t;

	// font store access from the sequencer
	typedef struct packed {
		logic               wr_en;
		logic               rd_en;
		logic [FONT_AW-1:0] addr;
		logic [CODE_W-1:0]  wdata;
	} font_req_t;

endpackage

/* rtl/core/ttg_item_if.sv */
interface ttg_item_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [7:0]  char_code;
	logic [15:0] fg_color;
	logic [15:0] back_color;
	logic [11:0] font_addr;
	logic [7:0]  font_byte;

	modport source (
		output valid, mode, char_code, fg_color, back_color, font_addr, font_byte,
		input  ready
	);
	modport sink (
		input  valid, mode, char_code, fg_color, back_color, font_addr, font_byte,
		output ready
	);
endinterface

/* rtl/core/ttg_result_if.sv */
interface ttg_result_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  pixel_x;
	logic [8:0]  pixel_y;
	logic [15:0] pix0;
	logic [15:0] pix1;
	logic [15:0] pix2;
	logic [15:0] pix3;
	logic [15:0] pix4;
	logic [15:0] pix5;
	logic [15:0] pix6;
	logic [15:0] pix7;
	logic        last;

	modport source (
		output valid, kind, pixel_x, pixel_y, pix0, pix1, pix2, pix3, pix4, pix5, pix6,
			pix7, last,
		input  ready
	);
	modport sink (
		input  valid, kind, pixel_x, pixel_y, pix0, pix1, pix2, pix3, pix4, pix5, pix6,
			pix7, last,
		output ready
	);
endinterface

/* rtl/core/text_tile_glyph_renderer_top.sv */
// Text-mode renderer for an 8x16 one-bit font on a character grid. A font write
// item (mode 1) is taken and gives no result. A character item (mode 0) gives
// an optional screen-clear result, when the cursor is at the top left or the
// code is home, followed by 16 glyph rows for a printable code; home and newline
// codes give at most the clear result. A printable character keeps the block
// busy until its last glyph row is read; while the output side keeps up, the
// single-port 4096 x 8 font store delivers one glyph row per cycle behind a
// registered read. The font store has no reset; entries must be written before
// they are used. Results leave through an output register, so a new item may be
// taken while the last result is still waiting.
module text_tile_glyph_renderer_top #(
	parameter int TEXT_COLUMNS = ttg_pkg::TEXT_COLUMNS_DEF,
	parameter int TEXT_ROWS    = ttg_pkg::TEXT_ROWS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ttg_item_if.sink      items,
	ttg_result_if.source  results
);
	import ttg_pkg::*;

	seq_state_t state_q, state_d;

	logic [CUR_W-1:0]   col_q, row_q;
	logic [CUR_W-1:0]   col_d, row_d;
	logic [CODE_W-1:0]  code_q;
	logic [COLOR_W-1:0] fg_q, bg_q;
	logic [X_W-1:0]     x_q;
	logic [Y_W-1:0]     ybase_q;
	logic               clear_last_q;
	logic               glyph_q;
	logic [ROW_W-1:0]   row_idx_q;

	logic               rd_valid_s1;
	logic [ROW_W-1:0]   row_idx_s1;

	result_t            out_q;
	logic               out_valid_q;

	logic               accept, render, at_home, is_home, is_newline;
	logic               out_free, clear_load, s1_load, issue;
	logic [CUR_W-1:0]   col_inc, row_inc, row_wrap;
	logic [CODE_W-1:0]  glyph_bits;
	font_req_t          font_req;

	// request handshake
	assign items.ready = (state_q == ST_IDLE) && !rd_valid_s1;
	assign accept      = items.valid && items.ready;
	assign render      = accept && (items.mode == MODE_RENDER);
	assign is_home     = items.char_code == CODE_HOME;
	assign is_newline  = items.char_code == CODE_NEWLINE;
	assign at_home     = (col_q == '0) && (row_q == '0);

	// output register and read stage flow
	assign out_free   = !out_valid_q || results.ready;
	assign s1_load    = rd_valid_s1 && out_free;
	assign clear_load = (state_q == ST_CLEAR) && out_free;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (render) begin
					if (is_home || at_home) begin
						state_d = ST_CLEAR;
					end else if (!is_newline) begin
						state_d = ST_GLYPH;
					end
				end
			end
			ST_CLEAR: begin
				if (out_free) begin
					state_d = glyph_q ? ST_GLYPH : ST_IDLE;
				end
			end
			ST_GLYPH: begin
				if (issue && (row_idx_q == LAST_ROW)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: font store access
	always_comb begin
		issue          = (state_q == ST_GLYPH) && (!rd_valid_s1 || s1_load);
		font_req.wr_en = accept && (items.mode == MODE_FONT);
		font_req.rd_en = issue;
		font_req.wdata = items.font_byte;
		font_req.addr  = font_req.wr_en ? items.font_addr : {code_q, row_idx_q};
	end

	// cursor advance for the accepted character
	always_comb begin
		col_inc  = col_q + CUR_W'(1);
		row_inc  = row_q + CUR_W'(1);
		col_d    = col_q;
		row_d    = row_q;
		if (is_home) begin
			col_d = '0;
			row_d = '0;
		end else if (is_newline) begin
			col_d = '0;
			row_d = row_inc;
		end else if (col_inc == CUR_W'(TEXT_COLUMNS)) begin
			col_d = '0;
			row_d = row_inc;
		end else begin
			col_d = col_inc;
		end
		row_wrap = (row_d == CUR_W'(TEXT_ROWS)) ? '0 : row_d;
	end

	ttg_font_mem u_font (
		.clk   (clk),
		.req   (font_req),
		.rdata (glyph_bits)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			row_idx_q   <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (render) begin
				col_q     <= col_d;
				row_q     <= row_wrap;
				row_idx_q <= '0;
			end else if (issue) begin
				row_idx_q <= row_idx_q + ROW_W'(1);
			end
			if (issue) begin
				rd_valid_s1 <= 1'b1;
			end else if (s1_load) begin
				rd_valid_s1 <= 1'b0;
			end
			if (clear_load || s1_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// captured character context
	always_ff @(posedge clk) begin
		if (render) begin
			code_q       <= items.char_code;
			fg_q         <= items.fg_color;
			bg_q         <= items.back_color;
			x_q          <= {col_q, 3'b000};
			ybase_q      <= {row_q, 4'b0000};
			clear_last_q <= is_home || is_newline;
			glyph_q      <= !is_home && !is_newline;
		end
		if (issue) begin
			row_idx_s1 <= row_idx_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		priority if (clear_load) begin
			out_q.kind    <= KIND_CLEAR;
			out_q.pixel_x <= '0;
			out_q.pixel_y <= '0;
			for (int i = 0; i < PIX_PER_ROW; i++) begin
				out_q.pix[i] <= bg_q;
			end
			out_q.last <= clear_last_q;
		end else if (s1_load) begin
			out_q.kind    <= KIND_GLYPH;
			out_q.pixel_x <= x_q;
			out_q.pixel_y <= ybase_q + Y_W'(row_idx_s1);
			for (int i = 0; i < PIX_PER_ROW; i++) begin
				out_q.pix[i] <= glyph_bits[PIX_PER_ROW-1-i] ? fg_q : bg_q;
			end
			out_q.last <= row_idx_s1 == LAST_ROW;
		end else begin
			out_q <= out_q;
		end
	end

	assign results.valid   = out_valid_q;
	assign results.kind    = out_q.kind;
	assign results.pixel_x = out_q.pixel_x;
	assign results.pixel_y = out_q.pixel_y;
	assign results.pix0    = out_q.pix[0];
	assign results.pix1    = out_q.pix[1];
	assign results.pix2    = out_q.pix[2];
	assign results.pix3    = out_q.pix[3];
	assign results.pix4    = out_q.pix[4];
	assign results.pix5    = out_q.pix[5];
	assign results.pix6    = out_q.pix[6];
	assign results.pix7    = out_q.pix[7];
	assign results.last    = out_q.last;

endmodule

/* rtl/core/ttg_font_mem.sv */
module ttg_font_mem (
	input  logic                 clk,
	input  ttg_pkg::font_req_t   req,
	output logic [7:0]           rdata
);
	import ttg_pkg::*;

	logic [CODE_W-1:0] mem [2**FONT_AW];
	logic [CODE_W-1:0] rdata_q;

	// single port: write wins, read data held until the next read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end else if (req.rd_en) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/ttg_checker.sv */
module ttg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        item_mode,
	input logic [7:0]  item_code,
	input logic        res_valid,
	input logic        res_ready,
	input logic        res_kind,
	input logic [7:0]  res_x,
	input logic [8:0]  res_y,
	input logic [15:0] res_pix0,
	input logic [15:0] res_pix7
);
	import ttg_pkg::*;

	logic item_acc;
	assign item_acc = item_valid && item_ready;

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_y) && $stable(res_pix0))
		else $error("result changed while stalled");

	// a printable character keeps the block busy
	a_glyph_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && (item_mode == MODE_RENDER) && (item_code != CODE_HOME)
			&& (item_code != CODE_NEWLINE) |=> !item_ready)
		else $error("request taken during glyph rendering");

	// a font write never blocks the next request
	a_font_free: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && (item_mode == MODE_FONT) |=> item_ready)
		else $error("font write left the block busy");

	// a clear result is anchored at the origin with one colour
	a_clear_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == KIND_CLEAR) |->
			(res_x == '0) && (res_y == '0) && (res_pix0 == res_pix7))
		else $error("malformed clear result");

endmodule

bind text_tile_glyph_renderer_top ttg_checker u_ttg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (items.valid),
	.item_ready (items.ready),
	.item_mode  (items.mode),
	.item_code  (items.char_code),
	.res_valid  (results.valid),
	.res_ready  (results.ready),
	.res_kind   (results.kind),
	.res_x      (results.pixel_x),
	.res_y      (results.pixel_y),
	.res_pix0   (results.pix0),
	.res_pix7   (results.pix7)
);

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import ttg_pkg::*;

	localparam int TEXT_COLUMNS = TEXT_COLUMNS_DEF;
	localparam int TEXT_ROWS    = TEXT_ROWS_DEF;
	localparam int ITEM_TARGET  = 210;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_AT      = 500;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LO     = 900;
	localparam int QUIET_HI     = 1300;
	localparam int TAIL_CYCLES  = 60;
	localparam int PRINT_CAP    = 40;

	typedef struct packed {
		logic               mode;
		logic [CODE_W-1:0]  code;
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] bg;
		logic [FONT_AW-1:0] addr;
		logic [7:0]         fbyte;
	} tile_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ttg_item_if   items_ch ();
	ttg_result_if results_ch ();

	text_tile_glyph_renderer_top #(
		.TEXT_COLUMNS (TEXT_COLUMNS),
		.TEXT_ROWS    (TEXT_ROWS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch),
		.results (results_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// requests waiting to be driven, and rows the screen should receive
	tile_req_t char_queue [$];
	result_t   expected_rows [$];

	int unsigned cycles = 0;
	int          fail_count = 0;
	int          total_cnt = 0;
	int          accepted_cnt = 0;
	int          hold_left = 0;

	// shadow of the block state
	logic [CUR_W-1:0] cur_col = '0;
	logic [CUR_W-1:0] cur_row = '0;
	logic [7:0]       font_copy [0:(1<<FONT_AW)-1];

	// font entries written so far, seen at generation time
	bit               font_seen [0:(1<<FONT_AW)-1];
	logic [CODE_W-1:0] ready_codes [$];

	task automatic note_mismatch(input string msg);
		fail_count++;
		if (fail_count <= PRINT_CAP)
			$display("ERROR @%0d: %s", cycles, msg);
	endtask

	function automatic bit idle_now();
		if (cycles >= QUIET_LO && cycles <= QUIET_HI)
			return 1'b0;
		return $urandom_range(99) < 6;
	endfunction

	// work out the rows caused by one accepted request
	task automatic render_char(input tile_req_t rq);
		result_t    r;
		logic [7:0] bits;
		if (rq.mode == MODE_FONT) begin
			font_copy[rq.addr] = rq.fbyte;
		end else begin
			if (rq.code == CODE_HOME) begin
				cur_col = '0;
				cur_row = '0;
			end
			// screen clear whenever the cursor sits at the top left
			if (cur_col == 0 && cur_row == 0) begin
				r.kind    = KIND_CLEAR;
				r.pixel_x = '0;
				r.pixel_y = '0;
				for (int i = 0; i < PIX_PER_ROW; i++)
					r.pix[i] = rq.bg;
				r.last = (rq.code == CODE_HOME) || (rq.code == CODE_NEWLINE);
				expected_rows.push_back(r);
			end
			if (rq.code == CODE_NEWLINE) begin
				cur_col = '0;
				cur_row = cur_row + 1'b1;
			end else if (rq.code != CODE_HOME) begin
				for (int j = 0; j < GLYPH_HEIGHT; j++) begin
					bits      = font_copy[{rq.code, 4'(j)}];
					r.kind    = KIND_GLYPH;
					r.pixel_x = {cur_col, 3'b000};
					r.pixel_y = Y_W'(cur_row * GLYPH_HEIGHT + j);
					for (int i = 0; i < PIX_PER_ROW; i++)
						r.pix[i] = bits[7-i] ? rq.fg : rq.bg;
					r.last = (j == GLYPH_HEIGHT - 1);
					expected_rows.push_back(r);
				end
				cur_col = cur_col + 1'b1;
				if (cur_col == TEXT_COLUMNS) begin
					cur_col = '0;
					cur_row = cur_row + 1'b1;
				end
			end
			if (cur_row == TEXT_ROWS)
				cur_row = '0;
		end
	endtask

	// request with every field random
	function automatic tile_req_t rand_req();
		tile_req_t rq;
		rq.mode  = 1'($urandom_range(1));
		rq.code  = 8'($urandom_range(255));
		rq.fg    = 16'($urandom_range(65535));
		rq.bg    = 16'($urandom_range(65535));
		rq.addr  = 12'($urandom_range(4095));
		rq.fbyte = 8'($urandom_range(255));
		return rq;
	endfunction

	function automatic logic [COLOR_W-1:0] rand_color();
		int unsigned p;
		p = $urandom_range(9);
		if (p == 0)
			return '0;
		if (p == 1)
			return '1;
		return 16'($urandom_range(65535));
	endfunction

	task automatic push_req(input tile_req_t rq);
		if (rq.mode == MODE_FONT)
			font_seen[rq.addr] = 1'b1;
		char_queue.push_back(rq);
		total_cnt++;
	endtask

	task automatic write_font(input logic [FONT_AW-1:0] addr, input logic [7:0] val);
		tile_req_t rq;
		rq       = rand_req();
		rq.mode  = MODE_FONT;
		rq.addr  = addr;
		rq.fbyte = val;
		push_req(rq);
	endtask

	// make sure all 16 rows of a glyph are written before it is drawn
	task automatic load_glyph(input logic [CODE_W-1:0] code);
		bit complete;
		complete = 1'b1;
		for (int j = 0; j < GLYPH_HEIGHT; j++)
			if (!font_seen[{code, 4'(j)}])
				complete = 1'b0;
		if (!complete) begin
			for (int j = 0; j < GLYPH_HEIGHT; j++)
				write_font({code, 4'(j)}, 8'($urandom_range(255)));
			ready_codes.push_back(code);
		end
	endtask

	task automatic add_glyph(input logic [CODE_W-1:0] code, input logic [COLOR_W-1:0] fg,
			input logic [COLOR_W-1:0] bg);
		tile_req_t rq;
		load_glyph(code);
		rq      = rand_req();
		rq.mode = MODE_RENDER;
		rq.code = code;
		rq.fg   = fg;
		rq.bg   = bg;
		push_req(rq);
	endtask

	task automatic add_ctrl(input logic [CODE_W-1:0] code);
		tile_req_t rq;
		rq      = rand_req();
		rq.mode = MODE_RENDER;
		rq.code = code;
		rq.bg   = rand_color();
		push_req(rq);
	endtask

	// mostly codes already in the font, now and then a fresh one
	function automatic logic [CODE_W-1:0] random_code();
		logic [CODE_W-1:0] code;
		if (ready_codes.size() != 0 && $urandom_range(99) >= 4)
			return ready_codes[$urandom_range(ready_codes.size() - 1)];
		do
			code = 8'($urandom_range(255));
		while (code == CODE_HOME || code == CODE_NEWLINE);
		return code;
	endfunction

	// stimulus
	initial begin
		tile_req_t rq;
		int unsigned seg;
		int unsigned n;

		// directed: glyphs with extreme codes and row patterns
		load_glyph(8'hff);
		write_font({8'hff, 4'd0}, 8'h00);
		write_font({8'hff, 4'd1}, 8'hff);
		write_font({8'hff, 4'd2}, 8'h80);
		write_font({8'hff, 4'd3}, 8'h01);
		load_glyph(8'h01);
		load_glyph(8'h80);
		load_glyph(8'h7f);
		add_glyph(8'hff, 16'hffff, 16'h0000);
		add_glyph(8'h01, 16'h0000, 16'hffff);
		add_ctrl(CODE_NEWLINE);
		add_glyph(8'h80, 16'haaaa, 16'h5555);
		add_ctrl(CODE_HOME);
		add_ctrl(CODE_NEWLINE);
		add_ctrl(CODE_HOME);
		add_ctrl(CODE_HOME);
		add_glyph(8'h7f, 16'h5555, 16'haaaa);
		write_font({8'h7f, 4'd15}, 8'h3c);
		add_glyph(8'h7f, 16'hffff, 16'hffff);
		add_glyph(8'hff, 16'h0000, 16'h0000);

		// walk to the bottom row and leave it by a full line, then by a newline
		for (int k = 0; k < 2; k++) begin
			add_ctrl(CODE_HOME);
			repeat (TEXT_ROWS - 1)
				add_ctrl(CODE_NEWLINE);
			if (k == 0)
				repeat (TEXT_COLUMNS)
					add_glyph(random_code(), rand_color(), rand_color());
			else
				add_ctrl(CODE_NEWLINE);
			add_glyph(random_code(), rand_color(), rand_color());
		end

		// random text segments
		while (total_cnt < ITEM_TARGET) begin
			seg = $urandom_range(99);
			if (seg < 40) begin
				n = $urandom_range(8, 1);
				repeat (n)
					add_glyph(random_code(), rand_color(), rand_color());
				add_ctrl(CODE_NEWLINE);
			end else if (seg < 48) begin
				repeat (TEXT_COLUMNS)
					add_glyph(random_code(), rand_color(), rand_color());
			end else if (seg < 56) begin
				add_ctrl(CODE_HOME);
			end else if (seg < 72) begin
				n = $urandom_range(3, 1);
				repeat (n)
					add_ctrl(CODE_NEWLINE);
			end else begin
				// noise: stray font writes and loose render requests
				rq = rand_req();
				if (rq.mode == MODE_RENDER) begin
					if (rq.code != CODE_HOME && rq.code != CODE_NEWLINE) begin
						if ($urandom_range(1) == 0)
							rq.code = random_code();
						load_glyph(rq.code);
					end
				end
				push_req(rq);
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_cnt != total_cnt)
			@(negedge clk);
		@(negedge clk);
		while (expected_rows.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin : drv
		tile_req_t on_wire;
		if (!arst_n) begin
			items_ch.valid      <= 1'b0;
			items_ch.mode       <= MODE_RENDER;
			items_ch.char_code  <= '0;
			items_ch.fg_color   <= '0;
			items_ch.back_color <= '0;
			items_ch.font_addr  <= '0;
			items_ch.font_byte  <= '0;
		end else begin
			if (items_ch.valid && items_ch.ready) begin
				render_char(on_wire);
				accepted_cnt++;
			end
			if (!items_ch.valid || items_ch.ready) begin
				if (char_queue.size() != 0 && !idle_now()) begin
					on_wire = char_queue.pop_front();
					items_ch.valid      <= 1'b1;
					items_ch.mode       <= on_wire.mode;
					items_ch.char_code  <= on_wire.code;
					items_ch.fg_color   <= on_wire.fg;
					items_ch.back_color <= on_wire.bg;
					items_ch.font_addr  <= on_wire.addr;
					items_ch.font_byte  <= on_wire.fbyte;
				end else begin
					items_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (cycles == HOLD_AT)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// result monitor and checker
	always @(posedge clk or negedge arst_n) begin : mon
		result_t got;
		result_t want;
		if (!arst_n) begin
			results_ch.ready <= 1'b0;
		end else begin
			if (results_ch.valid && results_ch.ready) begin
				got.kind    = results_ch.kind;
				got.pixel_x = results_ch.pixel_x;
				got.pixel_y = results_ch.pixel_y;
				got.pix[0]  = results_ch.pix0;
				got.pix[1]  = results_ch.pix1;
				got.pix[2]  = results_ch.pix2;
				got.pix[3]  = results_ch.pix3;
				got.pix[4]  = results_ch.pix4;
				got.pix[5]  = results_ch.pix5;
				got.pix[6]  = results_ch.pix6;
				got.pix[7]  = results_ch.pix7;
				got.last    = results_ch.last;
				if (expected_rows.size() == 0) begin
					note_mismatch($sformatf("unexpected row kind %0d x %0d y %0d",
						got.kind, got.pixel_x, got.pixel_y));
				end else begin
					want = expected_rows.pop_front();
					if (got.kind !== want.kind)
						note_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
					if (got.pixel_x !== want.pixel_x)
						note_mismatch($sformatf("pixel_x %0d, want %0d",
							got.pixel_x, want.pixel_x));
					if (got.pixel_y !== want.pixel_y)
						note_mismatch($sformatf("pixel_y %0d, want %0d",
							got.pixel_y, want.pixel_y));
					for (int i = 0; i < PIX_PER_ROW; i++)
						if (got.pix[i] !== want.pix[i])
							note_mismatch($sformatf("pix%0d %h, want %h at y %0d",
								i, got.pix[i], want.pix[i], want.pixel_y));
					if (got.last !== want.last)
						note_mismatch($sformatf("last %0d, want %0d at y %0d",
							got.last, want.last, want.pixel_y));
				end
			end
			results_ch.ready <= (hold_left == 0) && !idle_now();
		end
	end

	// cycle count and watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule
